/* src/clcls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcls_pkg: shared types and constants of the calibration count line smoother
// Widths of the request and result items, window geometry, register codes and
// the sequencer states.
// ----------------------------------------------------------------------------
package clcls_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int VALUE_W   = 16;
    localparam int SPL_W     = 7;
    localparam int LIMIT_W   = 10;
    localparam int SUM_W     = 16;
    localparam int CNT_W     = 7;
    localparam int POS_W     = 6;
    localparam int FRAC_W    = 6;

    // Line length clamp
    localparam int MAX_SPL   = 64;
    localparam int SPL_RESET = 10;

    // Window geometry
    localparam int NEIGH     = 3;
    localparam int WIN       = 2 * NEIGH + 1;
    localparam int WIN_IDX_W = $clog2(WIN);
    localparam int LINES_W   = $clog2(WIN + 1);
    localparam int HELD_W    = $clog2(NEIGH + 1);
    localparam int WGT_W     = $clog2(NEIGH + 2);
    localparam int WGT_SUM   = (NEIGH + 1) * (NEIGH + 1);
    localparam int ACC_W     = VALUE_W + $clog2(WGT_SUM);

    // Divider geometry
    localparam int QUO_W     = SUM_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPL   = 2'd0,
        CFG_LOWER = 2'd1,
        CFG_UPPER = 2'd2
    } t_cfg_idx;

    // Request and result items
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] line_value;
        logic               was_smoothed;
        logic               last;
        logic               empty_res;
    } t_out_item;

    // Controls from the sequencer to the window unit
    typedef struct packed {
        logic               push;
        logic [VALUE_W-1:0] push_value;
        logic               smooth_start;
        logic [WIN_IDX_W-1:0] rd_idx;
    } t_win_ctl;

    // Status from the window unit
    typedef struct packed {
        logic               smooth_done;
        logic [VALUE_W-1:0] smooth_value;
        logic [VALUE_W-1:0] center;
        logic [VALUE_W-1:0] rd_value;
    } t_win_stat;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DECIDE,
        S_SMOOTH_WAIT,
        S_LINE_OUT,
        S_EOS,
        S_FLUSH_LOAD,
        S_FLUSH_OUT,
        S_CLEAR
    } t_state;

endpackage

`default_nettype wire

/* src/calibration_count_line_smoother_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calibration_count_line_smoother_unit: scan line calibration count smoother
// Averages in-range counts per line, then applies a triangular moving average
// across 2N+1 line means, passing the first and last N lines through.
// ----------------------------------------------------------------------------
// A sample that closes a line starts the shared restoring divider (one quotient
// bit per cycle); after the start, done and decide states the line either
// returns to idle, sends a passed-through result, or first has a full window
// smoothed by the one-entry-per-cycle multiply-accumulate, and then waits for
// the result to be taken. At end of stream one state sets up the flush, each
// held line is loaded and then waits for the output handshake, and one more
// state clears the pass. The input is not ready while any of this work is in
// progress; configuration writes are taken in any cycle and must only be
// issued while idle.
// ----------------------------------------------------------------------------
module calibration_count_line_smoother_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire clcls_pkg::t_in_item              i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output clcls_pkg::t_out_item                  o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [clcls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [clcls_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import clcls_pkg::*;

    // Registers
    t_state             r_state;
    t_state             n_state;
    logic [SPL_W-1:0]   r_spl;
    logic [LIMIT_W-1:0] r_lo;
    logic [LIMIT_W-1:0] r_hi;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [POS_W-1:0]   r_pos;
    logic [LINES_W-1:0] r_lines;
    logic               r_eos;
    logic [HELD_W-1:0]  r_held;
    logic [HELD_W-1:0]  r_j;
    t_out_item          r_out;

    // Control strobes
    logic w_in_ready;
    logic w_out_valid;
    logic w_div_start;
    logic w_push;
    logic w_smooth_start;
    logic w_load_pass;
    logic w_load_smooth;
    logic w_load_empty;
    logic w_load_flush;
    logic w_set_held;
    logic w_next_j;
    logic w_clear;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_take;
    logic [SPL_W-1:0]   w_spl_eff;
    logic [SPL_W-1:0]   w_pos_inc;
    logic               w_line_end;
    logic               w_div_done;
    logic [VALUE_W-1:0] w_quot;
    logic [VALUE_W-1:0] w_mean;
    logic [HELD_W-1:0]  w_held;
    t_win_ctl           w_win_ctl;
    t_win_stat          w_win_stat;

    assign w_in_acc  = i_in_valid & w_in_ready;
    assign w_out_acc = w_out_valid & i_out_ready;

    // Clamp the line length into 1 .. MAX_SPL
    always_comb begin
        if (r_spl == '0) begin
            w_spl_eff = SPL_W'(1);
        end else if (r_spl > SPL_W'(MAX_SPL)) begin
            w_spl_eff = SPL_W'(MAX_SPL);
        end else begin
            w_spl_eff = r_spl;
        end
    end

    // Accept a sample when no limits are set or it lies inside them
    assign w_take = ((r_lo == '0) && (r_hi == '0)) ||
                    ((i_in_data.sample >= r_lo) && (i_in_data.sample <= r_hi));
    assign w_pos_inc  = SPL_W'(r_pos) + 1'b1;
    assign w_line_end = (w_pos_inc >= w_spl_eff);

    assign w_mean = (r_cnt == '0) ? '0 : w_quot;
    assign w_held = (r_lines < LINES_W'(NEIGH)) ? r_lines[HELD_W-1:0] : HELD_W'(NEIGH);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (w_line_end) begin
                        n_state = S_DIV_GO;
                    end else if (i_in_data.end_of_stream) begin
                        n_state = S_EOS;
                    end
                end
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_lines >= LINES_W'(WIN)) begin
                    n_state = S_SMOOTH_WAIT;
                end else if (r_lines >= LINES_W'(NEIGH + 1)) begin
                    n_state = S_LINE_OUT;
                end else if (r_eos) begin
                    n_state = S_EOS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SMOOTH_WAIT: begin
                if (w_win_stat.smooth_done) begin
                    n_state = S_LINE_OUT;
                end
            end
            S_LINE_OUT: begin
                if (w_out_acc) begin
                    n_state = r_eos ? S_EOS : S_IDLE;
                end
            end
            S_EOS: begin
                n_state = (r_lines == '0) ? S_FLUSH_OUT : S_FLUSH_LOAD;
            end
            S_FLUSH_LOAD: begin
                n_state = S_FLUSH_OUT;
            end
            S_FLUSH_OUT: begin
                if (w_out_acc) begin
                    n_state = r_out.last ? S_CLEAR : S_FLUSH_LOAD;
                end
            end
            S_CLEAR: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control outputs of each state
    always_comb begin
        w_in_ready     = 1'b0;
        w_out_valid    = 1'b0;
        w_div_start    = 1'b0;
        w_push         = 1'b0;
        w_smooth_start = 1'b0;
        w_load_pass    = 1'b0;
        w_load_smooth  = 1'b0;
        w_load_empty   = 1'b0;
        w_load_flush   = 1'b0;
        w_set_held     = 1'b0;
        w_next_j       = 1'b0;
        w_clear        = 1'b0;
        unique case (r_state)
            S_IDLE:        w_in_ready = 1'b1;
            S_DIV_GO:      w_div_start = 1'b1;
            S_DIV_WAIT:    w_push = w_div_done;
            S_DECIDE: begin
                w_smooth_start = (r_lines >= LINES_W'(WIN));
                w_load_pass    = (r_lines < LINES_W'(WIN)) &&
                                 (r_lines >= LINES_W'(NEIGH + 1));
            end
            S_SMOOTH_WAIT: w_load_smooth = w_win_stat.smooth_done;
            S_LINE_OUT:    w_out_valid = 1'b1;
            S_EOS: begin
                w_load_empty = (r_lines == '0);
                w_set_held   = 1'b1;
            end
            S_FLUSH_LOAD:  w_load_flush = 1'b1;
            S_FLUSH_OUT: begin
                w_out_valid = 1'b1;
                w_next_j    = i_out_ready;
            end
            S_CLEAR:       w_clear = 1'b1;
            default:       w_clear = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spl <= SPL_W'(SPL_RESET);
            r_lo  <= '0;
            r_hi  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPL:   r_spl <= i_cfg_data[SPL_W-1:0];
                CFG_LOWER: r_lo  <= i_cfg_data[LIMIT_W-1:0];
                CFG_UPPER: r_hi  <= i_cfg_data[LIMIT_W-1:0];
                default:   r_spl <= r_spl;
            endcase
        end
    end

    // Line accumulation, line count and pass bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_lines <= '0;
            r_eos   <= 1'b0;
            r_held  <= '0;
            r_j     <= '0;
        end else begin
            if (w_in_acc) begin
                r_eos <= i_in_data.end_of_stream;
                if (w_take) begin
                    r_sum <= r_sum + SUM_W'(i_in_data.sample);
                    r_cnt <= r_cnt + 1'b1;
                end
                r_pos <= w_line_end ? '0 : w_pos_inc[POS_W-1:0];
            end
            // Close the line: the mean enters the window
            if (w_push) begin
                r_sum <= '0;
                r_cnt <= '0;
                if (r_lines < LINES_W'(WIN)) begin
                    r_lines <= r_lines + 1'b1;
                end
            end
            if (w_set_held) begin
                r_held <= w_held;
                r_j    <= '0;
            end
            if (w_next_j) begin
                r_j <= r_j + 1'b1;
            end
            // Drop everything of the pass
            if (w_clear) begin
                r_sum   <= '0;
                r_cnt   <= '0;
                r_pos   <= '0;
                r_lines <= '0;
                r_eos   <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load_pass) begin
            r_out <= '{line_value: w_win_stat.center, was_smoothed: 1'b0,
                       last: 1'b0, empty_res: 1'b0};
        end else if (w_load_smooth) begin
            r_out <= '{line_value: w_win_stat.smooth_value, was_smoothed: 1'b1,
                       last: 1'b0, empty_res: 1'b0};
        end else if (w_load_empty) begin
            r_out <= '{line_value: '0, was_smoothed: 1'b0,
                       last: 1'b1, empty_res: 1'b1};
        end else if (w_load_flush) begin
            r_out <= '{line_value: w_win_stat.rd_value, was_smoothed: 1'b0,
                       last: (r_j + 1'b1 == r_held), empty_res: 1'b0};
        end
    end

    // Window controls
    assign w_win_ctl.push         = w_push;
    assign w_win_ctl.push_value   = w_mean;
    assign w_win_ctl.smooth_start = w_smooth_start;
    assign w_win_ctl.rd_idx       = WIN_IDX_W'(WIN) - WIN_IDX_W'(r_held) + WIN_IDX_W'(r_j);

    clcls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (r_sum),
        .i_count (r_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    clcls_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_win_ctl),
        .o_stat  (w_win_stat)
    );

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = w_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* src/clcls_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcls_div: iterative line mean divider
// Restoring divider, one quotient bit per cycle: (sum << 6) / count.
// ----------------------------------------------------------------------------
module clcls_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [clcls_pkg::SUM_W-1:0] i_sum,
    input  wire logic [clcls_pkg::CNT_W-1:0] i_count,
    output logic                             o_done,
    output logic [clcls_pkg::VALUE_W-1:0]    o_quot
);
    import clcls_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_step;
    logic [QUO_W-1:0]     r_num;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;

    logic [CNT_W:0]       w_rem_sh;
    logic                 w_ge;
    logic [CNT_W:0]       w_diff;

    // Shift one numerator bit into the partial remainder and try a subtract
    assign w_rem_sh = {r_rem, r_num[QUO_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    // Control: run QUO_W steps, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator register collects the quotient bits as it shifts
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_sum, FRAC_W'(0)};
            r_rem <= '0;
            r_den <= i_count;
        end else if (r_busy) begin
            r_num <= {r_num[QUO_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[VALUE_W-1:0];

endmodule

`default_nettype wire

/* src/clcls_win.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clcls_win: line window and triangular smoother
// Holds the last 2N+1 line means and forms the weighted sum one entry per
// cycle through a shared multiply-accumulate.
// ----------------------------------------------------------------------------
module clcls_win (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire clcls_pkg::t_win_ctl  i_ctl,
    output clcls_pkg::t_win_stat      o_stat
);
    import clcls_pkg::*;

    logic [VALUE_W-1:0]   r_win  [WIN];
    logic [VALUE_W-1:0]   r_work [WIN];
    logic [VALUE_W-1:0]   r_fill;
    logic [ACC_W-1:0]     r_acc;
    logic [WIN_IDX_W-1:0] r_step;
    logic                 r_busy;
    logic                 r_done;

    logic [VALUE_W-1:0]   w_fill;
    logic [VALUE_W-1:0]   w_term_v;
    logic [WGT_W-1:0]     w_wgt;
    logic [ACC_W-1:0]     w_prod;
    logic [ACC_W-1:0]     w_quot;

    // Find the earliest nonzero entry as the stand-in for zero entries
    always_comb begin
        w_fill = '0;
        for (int i = WIN - 1; i >= 0; i--) begin
            if (r_win[i] != '0) begin
                w_fill = r_win[i];
            end
        end
    end

    // Weight rises to N+1 at the center and falls off by one per line
    always_comb begin
        if (r_step <= WIN_IDX_W'(NEIGH)) begin
            w_wgt = WGT_W'(r_step) + 1'b1;
        end else begin
            w_wgt = WGT_W'(WIN_IDX_W'(WIN) - r_step);
        end
    end

    assign w_term_v = (r_work[0] != '0) ? r_work[0] : r_fill;
    assign w_prod   = ACC_W'(w_term_v) * ACC_W'(w_wgt);
    assign w_quot   = r_acc / ACC_W'(WGT_SUM);

    // Shift in the newest line mean at the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[WIN-1] <= i_ctl.push_value;
        end
    end

    // Sequence the accumulation over the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.smooth_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == WIN_IDX_W'(WIN - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Copy the window, then rotate it past the multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.smooth_start) begin
            for (int i = 0; i < WIN; i++) begin
                r_work[i] <= r_win[i];
            end
            r_fill <= w_fill;
            r_acc  <= '0;
        end else if (r_busy) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_work[i] <= r_work[i + 1];
            end
            r_work[WIN-1] <= r_work[0];
            r_acc <= r_acc + w_prod;
        end
    end

    assign o_stat.smooth_done  = r_done;
    assign o_stat.smooth_value = w_quot[VALUE_W-1:0];
    assign o_stat.center       = r_win[NEIGH];
    assign o_stat.rd_value     = r_win[i_ctl.rd_idx];

endmodule

`default_nettype wire
